>>> rtl/nlt_pkg.sv
// shared types, codes and constants of the node liveness tracker
package nlt_pkg;

  localparam int MAX_NODES_DEF = 32;

  localparam int AREA_W     = 6;
  localparam int HOLD_W     = 20;
  localparam int COUNT_W    = 6;
  localparam int FUNC_W     = 2;
  localparam int SLOT_W     = 5;
  localparam int ADDR_W     = 16;
  localparam int RTYPE_W    = 3;
  localparam int NTYPE_W    = 2;
  localparam int ELAPSED_W  = 16;
  localparam int NODE_IDX_W = 5;
  localparam int STATUS_W   = 3;
  localparam int AREA_LSB   = 10;

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [AREA_W-1:0]  LOCAL_AREA_RST = AREA_W'(7);
  localparam logic [HOLD_W-1:0]  HOLD_TIME_RST  = HOLD_W'(30000);
  localparam logic [COUNT_W-1:0] NODE_COUNT_RST = COUNT_W'(17);

  localparam logic [RTYPE_W-1:0] RTYPE_ROUTER_HELLO  = RTYPE_W'(5);
  localparam logic [RTYPE_W-1:0] RTYPE_ENDNODE_HELLO = RTYPE_W'(6);

  localparam logic [NTYPE_W-1:0] NTYPE_ROUTER2 = NTYPE_W'(1);
  localparam logic [NTYPE_W-1:0] NTYPE_ROUTER  = NTYPE_W'(2);
  localparam logic [NTYPE_W-1:0] NTYPE_ENDNODE = NTYPE_W'(3);

  typedef enum logic [STATUS_W-1:0] {
    ST_OFFLINE = 3'd0,
    ST_HELLO   = 3'd1,
    ST_ENDNODE = 3'd2,
    ST_ROUTER  = 3'd3,
    ST_ROUTER2 = 3'd4,
    ST_LOST    = 3'd5
  } node_status_t;

  typedef enum logic [FUNC_W-1:0] {
    FN_LOAD  = 2'd0,
    FN_HELLO = 2'd1,
    FN_TICK  = 2'd2,
    FN_NONE  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    REG_LOCAL_AREA = 2'd0,
    REG_HOLD_TIME  = 2'd1,
    REG_NODE_COUNT = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [AREA_W-1:0]  local_area;
    logic [HOLD_W-1:0]  hold_time_ms;
    logic [COUNT_W-1:0] node_count;
  } cfg_t;

  typedef struct packed {
    logic take;
    logic tbl_load;
    logic srch_init;
    logic srch_rd;
    logic srch_step;
    logic hello_wr;
    logic tick_init;
    logic tick_rd;
    logic tick_upd;
    logic flush;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_load;
    logic is_hello;
    logic is_tick;
    logic hello_ok;
    logic cnt_zero;
    logic srch_empty;
    logic srch_hit;
    logic srch_single;
    logic tick_last;
    logic tick_change;
    logic pend_valid;
    logic out_busy;
  } dp_stat_t;

endpackage

>>> rtl/nlt_ram.sv
// generic single write port ram with registered read
module nlt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/nlt_cfg.sv
// configuration registers behind the apb-style port
module nlt_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [nlt_pkg::PADDR_W-1:0]  paddr,
  input  logic [nlt_pkg::PDATA_W-1:0]  pwdata,
  output logic [nlt_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output nlt_pkg::cfg_t                cfg
);
  import nlt_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t reg_idx;
  logic     wr_en;

  assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.local_area   <= LOCAL_AREA_RST;
      cfg_r.hold_time_ms <= HOLD_TIME_RST;
      cfg_r.node_count   <= NODE_COUNT_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_LOCAL_AREA: cfg_r.local_area   <= pwdata[AREA_W-1:0];
        REG_HOLD_TIME:  cfg_r.hold_time_ms <= pwdata[HOLD_W-1:0];
        REG_NODE_COUNT: cfg_r.node_count   <= pwdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_LOCAL_AREA: prdata = PDATA_W'(cfg_r.local_area);
      REG_HOLD_TIME:  prdata = PDATA_W'(cfg_r.hold_time_ms);
      REG_NODE_COUNT: prdata = PDATA_W'(cfg_r.node_count);
      default:        prdata = '0;
    endcase
  end

endmodule

>>> rtl/nlt_ctrl.sv
// sequencer for load, hello search and tick aging
module nlt_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  nlt_pkg::dp_stat_t     stat,
  output nlt_pkg::ctrl_cmd_t    cmd
);
  import nlt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_TICK_RD,
    S_TICK_UPD,
    S_FLUSH
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_stall  = (state_r != S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take = 1'b1;
          priority if (stat.is_load) begin
            cmd.tbl_load = 1'b1;
          end else if (stat.is_hello && stat.hello_ok) begin
            cmd.srch_init = 1'b1;
            state_nxt     = S_SRCH_RD;
          end else if (stat.is_tick && !stat.cnt_zero) begin
            cmd.tick_init = 1'b1;
            state_nxt     = S_TICK_RD;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_SRCH_RD: begin
        if (stat.srch_empty) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.srch_rd = 1'b1;
          state_nxt   = S_SRCH_CMP;
        end
      end
      S_SRCH_CMP: begin
        priority if (stat.srch_hit) begin
          cmd.hello_wr = 1'b1;
          state_nxt    = S_FLUSH;
        end else if (stat.srch_single) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.srch_step = 1'b1;
          state_nxt     = S_SRCH_RD;
        end
      end
      S_TICK_RD: begin
        cmd.tick_rd = 1'b1;
        state_nxt   = S_TICK_UPD;
      end
      S_TICK_UPD: begin
        // a new report pushes the held one out, so wait for the output slot
        if (!(stat.tick_change && stat.pend_valid && stat.out_busy)) begin
          cmd.tick_upd = 1'b1;
          state_nxt    = stat.tick_last ? S_FLUSH : S_TICK_RD;
        end
      end
      S_FLUSH: begin
        if (!stat.pend_valid) begin
          state_nxt = S_IDLE;
        end else if (!stat.out_busy) begin
          cmd.flush = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> rtl/nlt_dp.sv
// tables, search window, tick walker and result registers
module nlt_dp #(
  parameter int MAX_NODES = nlt_pkg::MAX_NODES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  nlt_pkg::ctrl_cmd_t              cmd,
  output nlt_pkg::dp_stat_t               stat,
  input  nlt_pkg::cfg_t                   cfg,
  input  logic [nlt_pkg::FUNC_W-1:0]      in_func,
  input  logic [nlt_pkg::SLOT_W-1:0]      in_entry_index,
  input  logic [nlt_pkg::ADDR_W-1:0]      in_node_address,
  input  logic [nlt_pkg::RTYPE_W-1:0]     in_routing_type,
  input  logic [nlt_pkg::NTYPE_W-1:0]     in_node_type,
  input  logic [nlt_pkg::ELAPSED_W-1:0]   in_elapsed_ms,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [nlt_pkg::NODE_IDX_W-1:0]  out_node_index,
  output logic [nlt_pkg::STATUS_W-1:0]    out_node_status,
  output logic                            out_last
);
  import nlt_pkg::*;

  localparam int IDX_W  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CNT_W  = $clog2(MAX_NODES + 1);
  localparam int SW     = CNT_W + 1;
  localparam int SRAM_W = STATUS_W + HOLD_W;
  localparam logic signed [SW-1:0] ONE_S = SW'(1);

  // latched request fields
  logic [ADDR_W-1:0]    addr_r;
  logic [NTYPE_W-1:0]   ntype_r;
  logic [ELAPSED_W-1:0] elapsed_r;

  logic [CNT_W-1:0]     cnt_eff;
  logic signed [SW-1:0] lo_r, hi_r, diff, probe_s, probe_ext;
  logic [IDX_W-1:0]     probe_c, probe_r, idx_r;

  logic [ADDR_W-1:0]    addr_rd;
  logic [SRAM_W-1:0]    st_rd_data, st_wr_data;
  logic                 st_wr_en, rd_en;
  logic [IDX_W-1:0]     st_wr_addr, rd_addr;
  logic [MAX_NODES-1:0] vld_r;
  logic                 vld_rd_r;

  node_status_t         st_cur, hello_st, tick_st;
  logic [HOLD_W-1:0]    cd_cur, cd_dec, tick_cd, elapsed_ext;
  logic                 tick_offline, tick_change, push;

  logic                 pend_valid_r;
  logic [IDX_W-1:0]     pend_idx_r;
  node_status_t         pend_st_r;

  logic                 out_valid_r, out_last_r;
  logic [NODE_IDX_W-1:0] out_idx_r;
  logic [STATUS_W-1:0]  out_st_r;

  assign cnt_eff = (32'(cfg.node_count) > 32'(MAX_NODES)) ? CNT_W'(MAX_NODES)
                                                         : CNT_W'(cfg.node_count);

  // probe = lo + (hi-lo-1)/2, truncating toward zero, so lo when the window is one slot
  assign diff      = hi_r - lo_r - ONE_S;
  assign probe_s   = (hi_r > lo_r) ? (lo_r + (diff >>> 1)) : lo_r;
  assign probe_c   = probe_s[IDX_W-1:0];
  assign probe_ext = $signed(SW'(probe_r));

  // entries never written read as offline with a zero countdown
  assign st_cur = vld_rd_r ? node_status_t'(st_rd_data[SRAM_W-1 -: STATUS_W]) : ST_OFFLINE;
  assign cd_cur = vld_rd_r ? st_rd_data[HOLD_W-1:0] : '0;

  always_comb begin
    hello_st = st_cur;
    unique case (st_cur)
      ST_OFFLINE, ST_LOST: hello_st = ST_HELLO;
      ST_HELLO, ST_ENDNODE, ST_ROUTER: begin
        priority if (ntype_r == NTYPE_ENDNODE) begin
          hello_st = ST_ENDNODE;
        end else if (ntype_r == NTYPE_ROUTER) begin
          hello_st = ST_ROUTER;
        end else if (ntype_r == NTYPE_ROUTER2) begin
          hello_st = ST_ROUTER2;
        end else begin
          hello_st = st_cur;
        end
      end
      ST_ROUTER2: hello_st = st_cur;
      default:    hello_st = st_cur;
    endcase
  end

  assign elapsed_ext  = HOLD_W'(elapsed_r);
  assign cd_dec       = cd_cur - elapsed_ext;
  assign tick_offline = (st_cur == ST_OFFLINE);
  assign tick_change  = !tick_offline && !(cd_cur > elapsed_ext);
  assign tick_st      = (st_cur == ST_LOST) ? ST_OFFLINE : ST_LOST;
  assign tick_cd      = (st_cur == ST_LOST) ? '0 : cfg.hold_time_ms;

  assign st_wr_en   = cmd.hello_wr || (cmd.tick_upd && !tick_offline);
  assign st_wr_addr = cmd.hello_wr ? probe_r : idx_r;
  always_comb begin
    priority if (cmd.hello_wr) begin
      st_wr_data = {hello_st, cfg.hold_time_ms};
    end else if (tick_change) begin
      st_wr_data = {tick_st, tick_cd};
    end else begin
      st_wr_data = {st_cur, cd_dec};
    end
  end

  assign rd_en   = cmd.srch_rd || cmd.tick_rd;
  assign rd_addr = cmd.srch_rd ? probe_c : idx_r;

  nlt_ram #(.WIDTH(ADDR_W), .DEPTH(MAX_NODES), .AW(IDX_W)) u_addr_ram (
    .clk     (clk),
    .wr_en   (cmd.tbl_load && (32'(in_entry_index) < 32'(MAX_NODES))),
    .wr_addr (IDX_W'(in_entry_index)),
    .wr_data (in_node_address),
    .rd_en   (cmd.srch_rd),
    .rd_addr (probe_c),
    .rd_data (addr_rd)
  );

  nlt_ram #(.WIDTH(SRAM_W), .DEPTH(MAX_NODES), .AW(IDX_W)) u_state_ram (
    .clk     (clk),
    .wr_en   (st_wr_en),
    .wr_addr (st_wr_addr),
    .wr_data (st_wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (st_rd_data)
  );

  assign push = (cmd.tick_upd && tick_change && pend_valid_r) || (cmd.flush && pend_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r        <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (st_wr_en) begin
        vld_r[st_wr_addr] <= 1'b1;
      end
      if (cmd.hello_wr || (cmd.tick_upd && tick_change)) begin
        pend_valid_r <= 1'b1;
      end else if (cmd.flush) begin
        pend_valid_r <= 1'b0;
      end
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      addr_r    <= in_node_address;
      ntype_r   <= in_node_type;
      elapsed_r <= in_elapsed_ms;
    end
    if (rd_en) begin
      vld_rd_r <= vld_r[rd_addr];
    end
    if (cmd.srch_init) begin
      lo_r <= '0;
      hi_r <= $signed({1'b0, cnt_eff}) - ONE_S;
    end else if (cmd.srch_step) begin
      if (addr_rd > addr_r) begin
        hi_r <= probe_ext - ONE_S;
      end else begin
        lo_r <= probe_ext + ONE_S;
      end
    end
    if (cmd.srch_rd) begin
      probe_r <= probe_c;
    end
    if (cmd.tick_init) begin
      idx_r <= '0;
    end else if (cmd.tick_upd) begin
      idx_r <= idx_r + IDX_W'(1);
    end
    if (cmd.hello_wr) begin
      pend_idx_r <= probe_r;
      pend_st_r  <= hello_st;
    end else if (cmd.tick_upd && tick_change) begin
      pend_idx_r <= idx_r;
      pend_st_r  <= tick_st;
    end
    if (push) begin
      out_idx_r  <= NODE_IDX_W'(pend_idx_r);
      out_st_r   <= pend_st_r;
      out_last_r <= cmd.flush;
    end
  end

  assign stat.is_load     = (func_t'(in_func) == FN_LOAD);
  assign stat.is_hello    = (func_t'(in_func) == FN_HELLO);
  assign stat.is_tick     = (func_t'(in_func) == FN_TICK);
  assign stat.hello_ok    = (in_node_address[ADDR_W-1:AREA_LSB] == cfg.local_area)
                            && ((in_routing_type == RTYPE_ROUTER_HELLO)
                                || (in_routing_type == RTYPE_ENDNODE_HELLO));
  assign stat.cnt_zero    = (cnt_eff == '0);
  assign stat.srch_empty  = (lo_r > hi_r);
  assign stat.srch_hit    = (addr_rd == addr_r);
  assign stat.srch_single = (hi_r == lo_r);
  assign stat.tick_last   = (CNT_W'(idx_r) == (cnt_eff - CNT_W'(1)));
  assign stat.tick_change = tick_change;
  assign stat.pend_valid  = pend_valid_r;
  assign stat.out_busy    = out_valid_r;

  assign out_valid       = out_valid_r;
  assign out_node_index  = out_idx_r;
  assign out_node_status = out_st_r;
  assign out_last        = out_last_r;

endmodule

>>> rtl/network_node_liveness_tracker_unit.sv
// top level of the network node liveness tracker
// one request at a time; load and ignored requests end in the idle state, ready for the next request
// hello: accept, then a ram read and a compare per search probe, at most floor(log2(n-1))+2 probes
// for n of two or more, an end check if the window empties, and on a hit the report handover
// tick: accept, then a ram read and an update per slot in use, then the final report handover
// report handover waits while the output register is full; a held report does not block input
// synchronous reset clears control state and per-slot valid bits without a clear pass
module network_node_liveness_tracker_unit #(
  parameter int MAX_NODES = nlt_pkg::MAX_NODES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [nlt_pkg::FUNC_W-1:0]      in_func,
  input  logic [nlt_pkg::SLOT_W-1:0]      in_entry_index,
  input  logic [nlt_pkg::ADDR_W-1:0]      in_node_address,
  input  logic [nlt_pkg::RTYPE_W-1:0]     in_routing_type,
  input  logic [nlt_pkg::NTYPE_W-1:0]     in_node_type,
  input  logic [nlt_pkg::ELAPSED_W-1:0]   in_elapsed_ms,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [nlt_pkg::NODE_IDX_W-1:0]  out_node_index,
  output logic [nlt_pkg::STATUS_W-1:0]    out_node_status,
  output logic                            out_last,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [nlt_pkg::PADDR_W-1:0]     paddr,
  input  logic [nlt_pkg::PDATA_W-1:0]     pwdata,
  output logic [nlt_pkg::PDATA_W-1:0]     prdata,
  output logic                            pready
);
  import nlt_pkg::*;

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  dp_stat_t   stat;

  nlt_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  nlt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  nlt_dp #(.MAX_NODES(MAX_NODES)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .cfg             (cfg),
    .in_func         (in_func),
    .in_entry_index  (in_entry_index),
    .in_node_address (in_node_address),
    .in_routing_type (in_routing_type),
    .in_node_type    (in_node_type),
    .in_elapsed_ms   (in_elapsed_ms),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_node_index  (out_node_index),
    .out_node_status (out_node_status),
    .out_last        (out_last)
  );

endmodule

>>> tb/network_node_liveness_tracker_unit_test.sv
// self-checking testbench of the network node liveness tracker unit
module network_node_liveness_tracker_unit_test;
  import nlt_pkg::*;

  localparam int NODES           = MAX_NODES_DEF;
  localparam int RANDOM_ITEMS    = 120;
  localparam int CALM_ITEMS      = 30;
  localparam int SETTLE_CYCLES   = 100;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int STUCK_LIMIT     = 3000;

  typedef struct packed {
    func_t                  func;
    logic [SLOT_W-1:0]      slot;
    logic [ADDR_W-1:0]      addr;
    logic [RTYPE_W-1:0]     rtype;
    logic [NTYPE_W-1:0]     ntype;
    logic [ELAPSED_W-1:0]   elapsed;
  } request_t;

  typedef struct packed {
    logic [NODE_IDX_W-1:0] idx;
    node_status_t          st;
    logic                  last;
  } report_t;

  // one row of the directed plan: a register write or a request
  typedef struct {
    bit                    is_reg;
    reg_idx_t              reg_sel;
    logic [PDATA_W-1:0]    reg_val;
    request_t              req;
    int                    typed_n;
    logic [NODE_IDX_W-1:0] t_idx;
    node_status_t          t_st;
  } step_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [FUNC_W-1:0]     in_func = '0;
  logic [SLOT_W-1:0]     in_entry_index = '0;
  logic [ADDR_W-1:0]     in_node_address = '0;
  logic [RTYPE_W-1:0]    in_routing_type = '0;
  logic [NTYPE_W-1:0]    in_node_type = '0;
  logic [ELAPSED_W-1:0]  in_elapsed_ms = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [NODE_IDX_W-1:0] out_node_index;
  logic [STATUS_W-1:0]   out_node_status;
  logic                  out_last;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [PADDR_W-1:0]    paddr = '0;
  logic [PDATA_W-1:0]    pwdata = '0;
  logic [PDATA_W-1:0]    prdata;
  logic                  pready;

  network_node_liveness_tracker_unit #(.MAX_NODES(NODES)) u_top (.*);

  always #5 clk = ~clk;

  // tracker state as the block should hold it
  logic [ADDR_W-1:0]  node_addr_tbl [NODES];
  node_status_t       node_stat_tbl [NODES];
  logic [HOLD_W-1:0]  node_hold_left [NODES];
  logic [AREA_W-1:0]  area_reg = LOCAL_AREA_RST;
  logic [HOLD_W-1:0]  hold_reg = HOLD_TIME_RST;
  logic [COUNT_W-1:0] count_reg = NODE_COUNT_RST;

  report_t expected_reports[$];
  report_t new_reports[$];
  report_t oldest_report;
  int      n_errors = 0;
  int      n_items = 0;
  int      stuck_cycles = 0;
  bit      calm = 1'b0;
  bit      hold_off_req = 1'b0;

  function automatic int live_count();
    return (int'(count_reg) > NODES) ? NODES : int'(count_reg);
  endfunction

  function automatic int home_addr(int i);
    return 16'h1C00 + 3 + 20 * i;
  endfunction

  // binary search with the block's probe rule, the range check ends it
  function automatic int search_slot(logic [ADDR_W-1:0] a);
    int cnt;
    int lo;
    int hi;
    int probe;
    cnt = live_count();
    lo = 0;
    hi = cnt - 1;
    repeat (NODES + 1) begin
      if (lo < 0 || lo > cnt || hi < 0 || hi >= cnt || lo > hi) return -1;
      probe = lo + (hi - lo - 1) / 2;
      if (node_addr_tbl[probe] == a) return probe;
      if (hi == lo) return -1;
      if (node_addr_tbl[probe] > a) hi = probe - 1;
      else lo = probe + 1;
    end
    return -1;
  endfunction

  // applies one request to the tracker state, reports go to new_reports
  function automatic void track_request(request_t r);
    int idx;
    int i;
    node_status_t st;
    report_t rep;
    new_reports.delete();
    case (r.func)
      FN_LOAD: node_addr_tbl[r.slot] = r.addr;
      FN_HELLO: begin
        if (r.addr[ADDR_W-1:AREA_LSB] == area_reg &&
            (r.rtype == RTYPE_ROUTER_HELLO || r.rtype == RTYPE_ENDNODE_HELLO)) begin
          idx = search_slot(r.addr);
          if (idx >= 0) begin
            node_hold_left[idx] = hold_reg;
            st = node_stat_tbl[idx];
            case (st)
              ST_OFFLINE, ST_LOST: st = ST_HELLO;
              ST_HELLO, ST_ENDNODE, ST_ROUTER: begin
                if (r.ntype == NTYPE_ENDNODE) st = ST_ENDNODE;
                else if (r.ntype == NTYPE_ROUTER) st = ST_ROUTER;
                else if (r.ntype == NTYPE_ROUTER2) st = ST_ROUTER2;
              end
              default: ;
            endcase
            node_stat_tbl[idx] = st;
            rep.idx = NODE_IDX_W'(idx);
            rep.st = st;
            rep.last = 1'b1;
            new_reports.push_back(rep);
          end
        end
      end
      FN_TICK: begin
        for (i = 0; i < live_count(); i++) begin
          if (node_stat_tbl[i] != ST_OFFLINE) begin
            if (node_hold_left[i] > HOLD_W'(r.elapsed)) begin
              node_hold_left[i] -= HOLD_W'(r.elapsed);
            end else begin
              if (node_stat_tbl[i] == ST_LOST) begin
                node_stat_tbl[i] = ST_OFFLINE;
                node_hold_left[i] = '0;
              end else begin
                node_stat_tbl[i] = ST_LOST;
                node_hold_left[i] = hold_reg;
              end
              rep.idx = NODE_IDX_W'(i);
              rep.st = node_stat_tbl[i];
              rep.last = 1'b0;
              new_reports.push_back(rep);
            end
          end
        end
        if (new_reports.size() != 0) begin
          rep = new_reports.pop_back();
          rep.last = 1'b1;
          new_reports.push_back(rep);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic step_t item_step(func_t f, int slot, int addr, int rtype, int ntype,
                                      int el, int tn, int tidx, node_status_t tst);
    step_t s;
    s.is_reg = 1'b0;
    s.reg_sel = REG_LOCAL_AREA;
    s.reg_val = '0;
    s.req.func = f;
    s.req.slot = SLOT_W'(slot);
    s.req.addr = ADDR_W'(addr);
    s.req.rtype = RTYPE_W'(rtype);
    s.req.ntype = NTYPE_W'(ntype);
    s.req.elapsed = ELAPSED_W'(el);
    s.typed_n = tn;
    s.t_idx = NODE_IDX_W'(tidx);
    s.t_st = tst;
    return s;
  endfunction

  function automatic step_t reg_step(reg_idx_t sel, int val);
    step_t s;
    s = item_step(FN_NONE, 0, 0, 0, 0, 0, 0, 0, ST_OFFLINE);
    s.is_reg = 1'b1;
    s.reg_sel = sel;
    s.reg_val = PDATA_W'(val);
    return s;
  endfunction

  // typed_n below zero: expect what the tracker state gives
  task automatic send_request(request_t r, int typed_n, logic [NODE_IDX_W-1:0] t_idx,
                              node_status_t t_st);
    int gap;
    report_t rep;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_func <= r.func;
    in_entry_index <= r.slot;
    in_node_address <= r.addr;
    in_routing_type <= r.rtype;
    in_node_type <= r.ntype;
    in_elapsed_ms <= r.elapsed;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    track_request(r);
    if (typed_n < 0) begin
      foreach (new_reports[k]) expected_reports.push_back(new_reports[k]);
    end else if (typed_n == 1) begin
      rep.idx = t_idx;
      rep.st = t_st;
      rep.last = 1'b1;
      expected_reports.push_back(rep);
    end
    if (r.func != FN_NONE) n_items++;
  endtask

  // drop valid, let all reports arrive, then let a request with no report finish
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t sel, logic [PDATA_W-1:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'(int'(sel) * 4);
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    case (sel)
      REG_LOCAL_AREA: area_reg = val[AREA_W-1:0];
      REG_HOLD_TIME:  hold_reg = val[HOLD_W-1:0];
      REG_NODE_COUNT: count_reg = val[COUNT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      n_errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (expected_reports.size() == 0) begin
        $display("%0t: unexpected report index %0d status %0d last %0d", $time,
                 out_node_index, out_node_status, out_last);
        n_errors++;
      end else begin
        oldest_report = expected_reports.pop_front();
        check_field("node_index", int'(oldest_report.idx), int'(out_node_index));
        check_field("node_status", int'(oldest_report.st), int'(out_node_status));
        check_field("last", int'(oldest_report.last), int'(out_last));
      end
    end
  end

  // receiver side: random stall bursts, and one long hold-off on request
  initial begin
    int burst;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
        out_stall <= 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        burst = $urandom_range(1, 12);
        out_stall <= 1'b1;
        repeat (burst) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck_cycles <= 0;
      else stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    step_t    plan[$];
    request_t r;
    int       i;
    int       phase;
    int       start_items;
    int       area;
    int       hold;
    int       cnt;
    int       off;
    int       k;
    int       n_ops;

    for (i = 0; i < NODES; i++) begin
      node_addr_tbl[i] = '0;
      node_stat_tbl[i] = ST_OFFLINE;
      node_hold_left[i] = '0;
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // the whole address table first, so no search reads an unwritten slot
    for (i = 0; i < NODES; i++) begin
      r = '0;
      r.func = FN_LOAD;
      r.slot = SLOT_W'(i);
      r.addr = ADDR_W'(home_addr(i));
      send_request(r, -1, '0, ST_OFFLINE);
    end

    // reset settings: area 7, hold 30000, 17 nodes
    plan.push_back(item_step(FN_TICK, 0, 0, 0, 0, 100, 0, 0, ST_OFFLINE));
    plan.push_back(item_step(FN_HELLO, 0, home_addr(0), 5, 3, 0, 1, 0, ST_HELLO));
    plan.push_back(item_step(FN_HELLO, 0, home_addr(16), 6, 2, 0, 1, 16, ST_HELLO));
    plan.push_back(item_step(FN_HELLO, 0, home_addr(17), 5, 2, 0, 0, 0, ST_OFFLINE));
    plan.push_back(item_step(FN_HELLO, 0, home_addr(0), 5, 3, 0, 1, 0, ST_ENDNODE));
    plan.push_back(item_step(FN_HELLO, 0, home_addr(0), 6, 2, 0, 1, 0, ST_ROUTER));
    plan.push_back(item_step(FN_HELLO, 0, home_addr(0), 5, 0, 0, 1, 0, ST_ROUTER));
    plan.push_back(item_step(FN_HELLO, 0, home_addr(0), 5, 1, 0, 1, 0, ST_ROUTER2));
    plan.push_back(item_step(FN_HELLO, 0, home_addr(0), 6, 3, 0, 1, 0, ST_ROUTER2));
    // sender outside the local area, then a rejected message type
    plan.push_back(item_step(FN_HELLO, 0, home_addr(16) ^ 16'h0400, 5, 1, 0, 0, 0,
                             ST_OFFLINE));
    plan.push_back(item_step(FN_HELLO, 0, home_addr(16), 4, 1, 0, 0, 0, ST_OFFLINE));
    plan.push_back(item_step(FN_NONE, 31, 16'hFFFF, 7, 3, 16'hFFFF, 0, 0, ST_OFFLINE));
    plan.push_back(item_step(FN_LOAD, 31, 16'hFFFF, 0, 0, 0, 0, 0, ST_OFFLINE));
    plan.push_back(item_step(FN_LOAD, 0, 16'h0000, 0, 0, 0, 0, 0, ST_OFFLINE));
    plan.push_back(item_step(FN_HELLO, 0, 16'hFFFF, 5, 3, 0, 0, 0, ST_OFFLINE));
    plan.push_back(item_step(FN_LOAD, 0, home_addr(0), 0, 0, 0, 0, 0, ST_OFFLINE));
    // table briefly out of order
    plan.push_back(item_step(FN_LOAD, 3, home_addr(10), 0, 0, 0, 0, 0, ST_OFFLINE));
    plan.push_back(item_step(FN_HELLO, 0, home_addr(10), 5, 2, 0, -1, 0, ST_OFFLINE));
    plan.push_back(item_step(FN_LOAD, 3, home_addr(3), 0, 0, 0, 0, 0, ST_OFFLINE));
    plan.push_back(item_step(FN_TICK, 0, 0, 0, 0, 16'hFFFF, -1, 0, ST_OFFLINE));
    plan.push_back(item_step(FN_TICK, 0, 0, 0, 0, 29999, -1, 0, ST_OFFLINE));
    plan.push_back(item_step(FN_TICK, 0, 0, 0, 0, 1, -1, 0, ST_OFFLINE));
    // zero node count: nothing matches, nothing ages
    plan.push_back(reg_step(REG_NODE_COUNT, 0));
    plan.push_back(item_step(FN_HELLO, 0, home_addr(0), 5, 3, 0, 0, 0, ST_OFFLINE));
    plan.push_back(item_step(FN_TICK, 0, 0, 0, 0, 16'hFFFF, 0, 0, ST_OFFLINE));
    // count above the table size saturates, zero hold expires on the next tick
    plan.push_back(reg_step(REG_NODE_COUNT, 63));
    plan.push_back(reg_step(REG_HOLD_TIME, 0));
    plan.push_back(item_step(FN_HELLO, 0, home_addr(1), 5, 3, 0, 1, 1, ST_HELLO));
    plan.push_back(item_step(FN_TICK, 0, 0, 0, 0, 0, -1, 0, ST_OFFLINE));
    plan.push_back(item_step(FN_TICK, 0, 0, 0, 0, 0, -1, 0, ST_OFFLINE));

    foreach (plan[j]) begin
      if (plan[j].is_reg) begin
        wait_idle();
        write_reg(plan[j].reg_sel, plan[j].reg_val);
      end else begin
        send_request(plan[j].req, plan[j].typed_n, plan[j].t_idx, plan[j].t_st);
      end
    end

    phase = 0;
    start_items = n_items;
    while (!calm || n_items - start_items < RANDOM_ITEMS) begin
      wait_idle();
      if (phase == 0) begin
        area = 0;
        hold = 1;
        cnt = 1;
      end else if (phase == 1) begin
        area = 63;
        hold = 1048575;
        cnt = NODES;
      end else begin
        area = $urandom_range(0, 63);
        hold = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 1048575)
                                           : $urandom_range(1, 80000);
        k = $urandom_range(0, 9);
        cnt = (k == 0) ? 0 : (k == 1) ? $urandom_range(33, 63) : $urandom_range(1, NODES);
      end
      if (phase == 2) begin
        hold = $urandom_range(1, 20000);
        cnt = NODES;
      end
      write_reg(REG_LOCAL_AREA, PDATA_W'(area));
      write_reg(REG_HOLD_TIME, PDATA_W'(hold));
      write_reg(REG_NODE_COUNT, PDATA_W'(cnt));
      if (phase >= 3 && n_items - start_items >= RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;

      // fresh sorted table in the local area for the slots in use
      cnt = live_count();
      off = 0;
      for (i = 0; i < cnt; i++) begin
        off += $urandom_range(1, 1023 / (cnt + 1));
        r.func = FN_LOAD;
        r.slot = SLOT_W'(i);
        r.addr = {area_reg, 10'(off)};
        r.rtype = RTYPE_W'($urandom);
        r.ntype = NTYPE_W'($urandom);
        r.elapsed = ELAPSED_W'($urandom);
        send_request(r, -1, '0, ST_OFFLINE);
      end
      // receiver holds off while requests keep coming, so the block backs up
      if (phase == 2) hold_off_req = 1'b1;

      n_ops = $urandom_range(10, 20);
      repeat (n_ops) begin
        r.func = func_t'($urandom_range(0, 3));
        r.slot = SLOT_W'($urandom);
        r.addr = ADDR_W'($urandom);
        r.rtype = RTYPE_W'($urandom);
        r.ntype = NTYPE_W'($urandom);
        r.elapsed = ELAPSED_W'($urandom);
        k = $urandom_range(0, 99);
        if (k < 45 && cnt > 0) begin
          r.func = FN_HELLO;
          r.addr = node_addr_tbl[$urandom_range(0, cnt - 1)];
          r.rtype = ($urandom_range(0, 1) == 0) ? RTYPE_ROUTER_HELLO : RTYPE_ENDNODE_HELLO;
        end else if (k < 75) begin
          r.func = FN_TICK;
          case ($urandom_range(0, 3))
            0: ;
            1: r.elapsed = '1;
            2: r.elapsed = '0;
            default: begin
              r.elapsed = ELAPSED_W'($urandom_range(0, (hold_reg < 65535) ? hold_reg : 65535));
            end
          endcase
        end
        // otherwise fully random: foreign areas, bad types, stray loads
        send_request(r, -1, '0, ST_OFFLINE);
      end
      phase++;
    end

    wait_idle();
    if (n_errors == 0 && expected_reports.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
